>>> hdl/pstp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pstp_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int CORDIC_ITERS = 16;
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
    localparam int CORD_W       = 38;
    localparam int ANG_W        = 33;
    localparam int SUM_W        = 48;
    localparam int DIV_STEP_W   = $clog2(SUM_W);
    localparam int RAD_W        = 64;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int ROOT_STEP_W  = $clog2(ROOT_W);

    localparam int HALF_TURN    = 1800;
    localparam int FULL_TURN    = 3600;
    localparam int QUARTER_TURN = 900;

    localparam logic [2:0] REG_R0_C01 = 3'd0;
    localparam logic [2:0] REG_R0_C23 = 3'd1;
    localparam logic [2:0] REG_R1_C01 = 3'd2;
    localparam logic [2:0] REG_R1_C23 = 3'd3;
    localparam logic [2:0] REG_R2_C01 = 3'd4;
    localparam logic [2:0] REG_R2_C23 = 3'd5;
    localparam logic [2:0] REG_MODE   = 3'd6;

    // atan(2^-i) in tenths of a degree, Q16
    function automatic logic [25:0] atan_lut(input logic [4:0] i);
        logic [25:0] v;
        case (i)
            5'd0:    v = 26'd29491200;
            5'd1:    v = 26'd17409672;
            5'd2:    v = 26'd9198793;
            5'd3:    v = 26'd4669451;
            5'd4:    v = 26'd2343786;
            5'd5:    v = 26'd1173036;
            5'd6:    v = 26'd586661;
            5'd7:    v = 26'd293348;
            5'd8:    v = 26'd146676;
            5'd9:    v = 26'd73338;
            5'd10:   v = 26'd36669;
            5'd11:   v = 26'd18335;
            5'd12:   v = 26'd9167;
            5'd13:   v = 26'd4584;
            5'd14:   v = 26'd2292;
            5'd15:   v = 26'd1146;
            5'd16:   v = 26'd573;
            5'd17:   v = 26'd286;
            5'd18:   v = 26'd143;
            5'd19:   v = 26'd72;
            5'd20:   v = 26'd36;
            5'd21:   v = 26'd18;
            5'd22:   v = 26'd9;
            5'd23:   v = 26'd4;
            5'd24:   v = 26'd2;
            5'd25:   v = 26'd1;
            5'd26:   v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pstp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module pstp_isqrt
    import pstp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  value,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ROOT_STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]       val_reg, val_next;
    logic [ROOT_W+2:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [ROOT_W+2:0]      rem_sh, trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg[ROOT_W:0], val_reg[RAD_W-1:RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            // two radicand bits per step
            val_next = {val_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == ROOT_STEP_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> hdl/pstp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pstp_div
    import pstp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [SUM_W-1:0]      quot,
    output logic                  rem_nz
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]      q_reg, q_next;
    logic [CNT_W:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]      dvs_reg, dvs_next;
    logic [CNT_W:0]        rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // restoring step, quotient bits shift in from the bottom
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done   = done_reg;
    assign quot   = q_reg;
    assign rem_nz = (rem_reg != '0);

endmodule
`default_nettype wire

>>> hdl/point_set_to_pan_tilt_range.sv
`timescale 1ns / 1ps
`default_nettype none
// one word at a time; s_tready is high only while the sequencer is idle
// mode 0: nine products through the one 32x32 multiplier, each in a multiply state and
//   an accumulate state, plus the idle and output states
// mode 1: transform, squares, two 32-step roots and two CORDIC passes per word; a word
//   marked last adds three 48-step divisions
// reset (synchronous, active low): identity matrix, no translation, mode 1, sums and count cleared
module point_set_to_pan_tilt_range
    import pstp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // in_x, in_y, in_z
    input  wire logic         s_tlast,   // last_point
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // out_x, out_y, out_z, pan, tilt, distance, zero pad
    output logic              m_tlast    // end_of_set
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MUL   = 5'd1;
    localparam logic [4:0] ST_ACC   = 5'd2;
    localparam logic [4:0] ST_SQ    = 5'd3;
    localparam logic [4:0] ST_SQACC = 5'd4;
    localparam logic [4:0] ST_RT1S  = 5'd5;
    localparam logic [4:0] ST_RT1W  = 5'd6;
    localparam logic [4:0] ST_RT2S  = 5'd7;
    localparam logic [4:0] ST_RT2W  = 5'd8;
    localparam logic [4:0] ST_CSET  = 5'd9;
    localparam logic [4:0] ST_CIT   = 5'd10;
    localparam logic [4:0] ST_CFIN  = 5'd11;
    localparam logic [4:0] ST_ACCUM = 5'd12;
    localparam logic [4:0] ST_DS    = 5'd13;
    localparam logic [4:0] ST_DW    = 5'd14;
    localparam logic [4:0] ST_PFIN  = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(HALF_TURN * 65536);

    logic [4:0]               state_reg, state_next;
    logic [63:0]              coef01_reg [3];
    logic [63:0]              coef23_reg [3];
    logic                     mode_reg;

    logic signed [31:0]       pt_reg [3];
    logic signed [31:0]       pt_next [3];
    logic                     last_reg, last_next;
    logic [1:0]               row_reg, row_next;
    logic [1:0]               col_reg, col_next;
    logic signed [63:0]       p_reg, p_next;
    logic signed [51:0]       acc_reg, acc_next;
    logic signed [31:0]       t_reg [3];
    logic signed [31:0]       t_next [3];
    logic [63:0]              sumsq_reg, sumsq_next;
    logic [63:0]              hxy_reg, hxy_next;
    logic [31:0]              dist_reg, dist_next;
    logic [31:0]              hroot_reg, hroot_next;
    logic signed [CORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0]  ang_reg, ang_next;
    logic [ITER_W-1:0]        it_reg, it_next;
    logic                     csel_reg, csel_next;
    logic signed [11:0]       az_reg, az_next;
    logic [10:0]              pol_reg, pol_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [31:0]              pan_sum_reg, pan_sum_next;
    logic [31:0]              tilt_sum_reg, tilt_sum_next;
    logic [SUM_W-1:0]         dist_sum_reg, dist_sum_next;
    logic [1:0]               dsel_reg, dsel_next;
    logic [SUM_W-1:0]         pq_reg, pq_next, tq_reg, tq_next, dq_reg, dq_next;
    logic                     pnz_reg, pnz_next;
    logic [11:0]              res_pan_reg, res_pan_next;
    logic [9:0]               res_tilt_reg, res_tilt_next;
    logic [31:0]              res_dist_reg, res_dist_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [31:0]       o_x_reg, o_x_next, o_y_reg, o_y_next, o_z_reg, o_z_next;
    logic [11:0]              o_pan_reg, o_pan_next;
    logic [9:0]               o_tilt_reg, o_tilt_next;
    logic [31:0]              o_dist_reg, o_dist_next;
    logic                     o_last_reg, o_last_next;

    logic signed [31:0]       mul_a, mul_b, coef_sel, c3;
    logic signed [63:0]       prod;
    logic signed [51:0]       sum, tsum;
    logic signed [31:0]       tsat;
    logic signed [CORD_W-1:0] xin, yin;
    logic signed [ANG_W-1:0]  rnd;
    logic signed [16:0]       ang_r;
    logic [ITER_W-1:0]        it_last;
    logic                     rt_start;
    logic [RAD_W-1:0]         rt_value;
    logic                     rt_done;
    logic [ROOT_W-1:0]        rt_root;
    logic                     dv_start;
    logic [SUM_W-1:0]         dv_dividend;
    logic [CNT_W-1:0]         cnt_eff;
    logic                     dv_done;
    logic [SUM_W-1:0]         dv_quot;
    logic                     dv_rem_nz;
    logic [32:0]              pan_ext, pan_mag;
    logic [11:0]              pm;

    assign it_last = ITER_W'(CORDIC_ITERS);
    assign cnt_eff = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign pan_ext = {pan_sum_reg[31], pan_sum_reg};
    assign pan_mag = pan_sum_reg[31] ? (33'd0 - pan_ext) : pan_ext;

    // the one shared multiplier
    always_comb begin
        case (col_reg)
            2'd0:    coef_sel = signed'(coef01_reg[row_reg][63:32]);
            2'd1:    coef_sel = signed'(coef01_reg[row_reg][31:0]);
            default: coef_sel = signed'(coef23_reg[row_reg][63:32]);
        endcase
        c3 = signed'(coef23_reg[row_reg][31:0]);
        if (state_reg == ST_SQ) begin
            mul_a = t_reg[col_reg];
            mul_b = t_reg[col_reg];
        end else begin
            mul_a = coef_sel;
            mul_b = pt_reg[col_reg];
        end
        prod = mul_a * mul_b;
    end

    always_comb begin
        rt_start    = (state_reg == ST_RT1S) || (state_reg == ST_RT2S);
        rt_value    = (state_reg == ST_RT1S) ? sumsq_reg : hxy_reg;
        dv_start    = (state_reg == ST_DS);
        case (dsel_reg)
            2'd0:    dv_dividend = SUM_W'(pan_mag);
            2'd1:    dv_dividend = SUM_W'(tilt_sum_reg);
            default: dv_dividend = dist_sum_reg;
        endcase
    end

    pstp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rt_start),
        .value   (rt_value),
        .done    (rt_done),
        .root    (rt_root)
    );

    pstp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (cnt_eff),
        .done     (dv_done),
        .quot     (dv_quot),
        .rem_nz   (dv_rem_nz)
    );

    always_comb begin
        state_next    = state_reg;
        pt_next       = pt_reg;
        last_next     = last_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        p_next        = p_reg;
        acc_next      = acc_reg;
        t_next        = t_reg;
        sumsq_next    = sumsq_reg;
        hxy_next      = hxy_reg;
        dist_next     = dist_reg;
        hroot_next    = hroot_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        ang_next      = ang_reg;
        it_next       = it_reg;
        csel_next     = csel_reg;
        az_next       = az_reg;
        pol_next      = pol_reg;
        count_next    = count_reg;
        pan_sum_next  = pan_sum_reg;
        tilt_sum_next = tilt_sum_reg;
        dist_sum_next = dist_sum_reg;
        dsel_next     = dsel_reg;
        pq_next       = pq_reg;
        tq_next       = tq_reg;
        dq_next       = dq_reg;
        pnz_next      = pnz_reg;
        res_pan_next  = res_pan_reg;
        res_tilt_next = res_tilt_reg;
        res_dist_next = res_dist_reg;
        m_valid_next  = m_valid_reg;
        o_x_next      = o_x_reg;
        o_y_next      = o_y_reg;
        o_z_next      = o_z_reg;
        o_pan_next    = o_pan_reg;
        o_tilt_next   = o_tilt_reg;
        o_dist_next   = o_dist_reg;
        o_last_next   = o_last_reg;

        sum  = acc_reg + 52'(p_reg >>> 16);
        tsum = sum + 52'(c3);
        if (tsum > 52'sd2147483647) begin
            tsat = 32'sh7fffffff;
        end else if (tsum < -52'sd2147483648) begin
            tsat = 32'sh80000000;
        end else begin
            tsat = 32'(tsum);
        end
        if (csel_reg) begin
            yin = CORD_W'({1'b0, hroot_reg});
            xin = CORD_W'(t_reg[2]);
        end else begin
            yin = CORD_W'(t_reg[1]);
            xin = CORD_W'(t_reg[0]);
        end
        rnd   = ang_reg + ANG_W'(32768);
        ang_r = rnd[ANG_W-1:16];
        pm    = pq_reg[11:0] + 12'(pnz_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pt_next[0] = signed'(s_tdata[31:0]);
                    pt_next[1] = signed'(s_tdata[63:32]);
                    pt_next[2] = signed'(s_tdata[95:64]);
                    last_next  = s_tlast;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    acc_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                p_next     = prod;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                if (col_reg == 2'd2) begin
                    t_next[row_reg] = tsat;
                    acc_next = '0;
                    col_next = 2'd0;
                    if (row_reg == 2'd2) begin
                        state_next = mode_reg ? ST_SQ : ST_OUT;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    acc_next = sum;
                    col_next = col_reg + 1'b1;
                end
            end
            ST_SQ: begin
                p_next     = prod;
                state_next = ST_SQACC;
            end
            ST_SQACC: begin
                state_next = ST_SQ;
                col_next   = col_reg + 1'b1;
                case (col_reg)
                    2'd0: sumsq_next = unsigned'(p_reg);
                    2'd1: begin
                        sumsq_next = sumsq_reg + unsigned'(p_reg);
                        hxy_next   = sumsq_reg + unsigned'(p_reg);
                    end
                    default: begin
                        sumsq_next = sumsq_reg + unsigned'(p_reg);
                        state_next = ST_RT1S;
                    end
                endcase
            end
            ST_RT1S: state_next = ST_RT1W;
            ST_RT1W: begin
                if (rt_done) begin
                    dist_next  = rt_root;
                    state_next = ST_RT2S;
                end
            end
            ST_RT2S: state_next = ST_RT2W;
            ST_RT2W: begin
                if (rt_done) begin
                    hroot_next = rt_root;
                    csel_next  = 1'b0;
                    state_next = ST_CSET;
                end
            end
            ST_CSET: begin
                // fold the left half plane onto the right
                if (xin < 0) begin
                    ang_next = (yin >= 0) ? ANG_HALF : -ANG_HALF;
                    cx_next  = -xin;
                    cy_next  = -yin;
                end else begin
                    ang_next = '0;
                    cx_next  = xin;
                    cy_next  = yin;
                end
                it_next    = '0;
                state_next = ST_CIT;
            end
            ST_CIT: begin
                if (it_reg == it_last) begin
                    state_next = ST_CFIN;
                end else begin
                    if (cy_reg > 0) begin
                        cx_next  = cx_reg + (cy_reg >>> it_reg);
                        cy_next  = cy_reg - (cx_reg >>> it_reg);
                        ang_next = ang_reg + ANG_W'(atan_lut(5'(it_reg)));
                    end else begin
                        cx_next  = cx_reg - (cy_reg >>> it_reg);
                        cy_next  = cy_reg + (cx_reg >>> it_reg);
                        ang_next = ang_reg - ANG_W'(atan_lut(5'(it_reg)));
                    end
                    it_next = it_reg + 1'b1;
                end
            end
            ST_CFIN: begin
                if (!csel_reg) begin
                    if (hroot_reg == '0) begin
                        az_next = '0;
                    end else if (ang_r > 17'sd1800) begin
                        az_next = 12'(HALF_TURN);
                    end else if (ang_r < -17'sd1800) begin
                        az_next = -12'(HALF_TURN);
                    end else begin
                        az_next = 12'(ang_r);
                    end
                    csel_next  = 1'b1;
                    state_next = ST_CSET;
                end else begin
                    if (dist_reg == '0) begin
                        pol_next = 11'(QUARTER_TURN);
                    end else if (ang_r > 17'sd1800) begin
                        pol_next = 11'(HALF_TURN);
                    end else if (ang_r < 0) begin
                        pol_next = '0;
                    end else begin
                        pol_next = 11'(ang_r);
                    end
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                // points beyond the set limit are left out of the sums
                if (count_reg < CNT_W'(MAX_POINTS)) begin
                    pan_sum_next  = pan_sum_reg + 32'(az_reg);
                    tilt_sum_next = tilt_sum_reg + 32'(pol_reg);
                    dist_sum_next = dist_sum_reg + SUM_W'(dist_reg);
                    count_next    = count_reg + 1'b1;
                end
                dsel_next  = 2'd0;
                state_next = last_reg ? ST_DS : ST_IDLE;
            end
            ST_DS: state_next = ST_DW;
            ST_DW: begin
                if (dv_done) begin
                    state_next = ST_DS;
                    dsel_next  = dsel_reg + 1'b1;
                    case (dsel_reg)
                        2'd0: begin
                            pq_next  = dv_quot;
                            pnz_next = dv_rem_nz;
                        end
                        2'd1: tq_next = dv_quot;
                        default: begin
                            dq_next    = dv_quot;
                            state_next = ST_PFIN;
                        end
                    endcase
                end
            end
            ST_PFIN: begin
                // floor of a negative mean, then wrap into one turn
                if (pan_sum_reg[31]) begin
                    res_pan_next = (pm == '0) ? '0 : (12'(FULL_TURN) - pm);
                end else begin
                    res_pan_next = pq_reg[11:0];
                end
                res_tilt_next = (tq_reg > SUM_W'(QUARTER_TURN)) ?
                                10'(tq_reg - SUM_W'(QUARTER_TURN)) : '0;
                res_dist_next = (dq_reg[SUM_W-1:32] != '0) ? 32'hffffffff : dq_reg[31:0];
                count_next    = '0;
                pan_sum_next  = '0;
                tilt_sum_next = '0;
                dist_sum_next = '0;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_last_next  = last_reg;
                    if (mode_reg) begin
                        o_x_next    = '0;
                        o_y_next    = '0;
                        o_z_next    = '0;
                        o_pan_next  = res_pan_reg;
                        o_tilt_next = res_tilt_reg;
                        o_dist_next = res_dist_reg;
                    end else begin
                        o_x_next    = t_reg[0];
                        o_y_next    = t_reg[1];
                        o_z_next    = t_reg[2];
                        o_pan_next  = '0;
                        o_tilt_next = '0;
                        o_dist_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            coef01_reg[0] <= 64'h0001_0000_0000_0000;
            coef23_reg[0] <= 64'h0;
            coef01_reg[1] <= 64'h0000_0000_0001_0000;
            coef23_reg[1] <= 64'h0;
            coef01_reg[2] <= 64'h0;
            coef23_reg[2] <= 64'h0001_0000_0000_0000;
            mode_reg      <= 1'b1;
            count_reg     <= '0;
            pan_sum_reg   <= '0;
            tilt_sum_reg  <= '0;
            dist_sum_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
            pan_sum_reg  <= pan_sum_next;
            tilt_sum_reg <= tilt_sum_next;
            dist_sum_reg <= dist_sum_next;
            if (cfg_wr_en) begin
                if (cfg_addr <= REG_R2_C23) begin
                    if (cfg_addr[0]) begin
                        coef23_reg[cfg_addr[2:1]] <= cfg_wr_data;
                    end else begin
                        coef01_reg[cfg_addr[2:1]] <= cfg_wr_data;
                    end
                end else if (cfg_addr == REG_MODE) begin
                    mode_reg <= cfg_wr_data[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg       <= pt_next;
        last_reg     <= last_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        t_reg        <= t_next;
        sumsq_reg    <= sumsq_next;
        hxy_reg      <= hxy_next;
        dist_reg     <= dist_next;
        hroot_reg    <= hroot_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        ang_reg      <= ang_next;
        it_reg       <= it_next;
        csel_reg     <= csel_next;
        az_reg       <= az_next;
        pol_reg      <= pol_next;
        dsel_reg     <= dsel_next;
        pq_reg       <= pq_next;
        tq_reg       <= tq_next;
        dq_reg       <= dq_next;
        pnz_reg      <= pnz_next;
        res_pan_reg  <= res_pan_next;
        res_tilt_reg <= res_tilt_next;
        res_dist_reg <= res_dist_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_z_reg      <= o_z_next;
        o_pan_reg    <= o_pan_next;
        o_tilt_reg   <= o_tilt_next;
        o_dist_reg   <= o_dist_next;
        o_last_reg   <= o_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, o_dist_reg, o_tilt_reg, o_pan_reg, o_z_reg, o_y_reg, o_x_reg};
    assign m_tlast  = o_last_reg;

endmodule
`default_nettype wire

>>> tb/tb_point_set_to_pan_tilt_range.sv
`timescale 1ns / 1ps
module tb_point_set_to_pan_tilt_range;
    import pstp_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 500;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [11:0] pan;
        logic [9:0]  tilt;
        logic [31:0] rng;
        logic        eos;
    } pose_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        mode;
        logic        typed;
        pose_t       res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [2:0]   cfg_addr    = REG_R0_C01;
    logic [63:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata     = '0;   // in_x, in_y, in_z
    logic         s_tlast     = 1'b0; // last_point
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [151:0] m_tdata;            // out_x, out_y, out_z, pan, tilt, distance, zero pad
    logic         m_tlast;            // end_of_set

    point_set_to_pan_tilt_range u_top (.*);

    // predictor copy of registers and accumulators
    logic [63:0] coef_q [6];
    logic        mode_q;
    int unsigned pt_count;
    logic [31:0] pan_acc;
    logic [31:0] tilt_acc;
    logic [47:0] dist_acc;

    pose_t pose_q[$];
    int    errors    = 0;
    int    sidle_pct = 0;
    int    ridle_pct = 0;
    int    hold_req  = 0;
    int    hold_seen = 0;
    int    hold_left = 0;
    int    still_cnt = 0;

    longint atan_q16 [32] = '{
        29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
        146676, 73338, 36669, 18335, 9167, 4584, 2292, 1146,
        573, 286, 143, 72, 36, 18, 9, 4, 2, 1, 1, 0, 0, 0, 0, 0};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint affine_row(int r, longint x, longint y, longint z);
        longint c0, c1, c2, c3;
        c0 = longint'($signed(coef_q[2*r][63:32]));
        c1 = longint'($signed(coef_q[2*r][31:0]));
        c2 = longint'($signed(coef_q[2*r+1][63:32]));
        c3 = longint'($signed(coef_q[2*r+1][31:0]));
        return sat32(((c0 * x) >>> 16) + ((c1 * y) >>> 16) + ((c2 * z) >>> 16) + c3);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // vectoring rotation, angle in whole tenths of a degree
    function automatic longint vector_angle(longint y, longint x);
        longint ang, nx, ny;
        ang = 0;
        if (x < 0) begin
            ang = (y >= 0) ? 1800 * 65536 : -1800 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_ITERS && i < 32; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                ang += atan_q16[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                ang -= atan_q16[i];
            end
            x = nx;
            y = ny;
        end
        return (ang + 32768) >>> 16;
    endfunction

    function automatic longint unsigned sqr(longint v);
        longint unsigned a;
        a = (v < 0) ? longint'(-v) : longint'(v);
        return a * a;
    endfunction

    function automatic bit predict_pose(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                                        logic last, output pose_t res);
        longint x, y, z, tx, ty, tz, az, pol, s, pavg;
        longint unsigned hxy, rng, cnt, tavg, davg;
        x = longint'($signed(ix));
        y = longint'($signed(iy));
        z = longint'($signed(iz));
        tx = affine_row(0, x, y, z);
        ty = affine_row(1, x, y, z);
        tz = affine_row(2, x, y, z);
        res = '0;
        if (mode_q == 1'b0) begin
            res.ox = tx[31:0];
            res.oy = ty[31:0];
            res.oz = tz[31:0];
            res.eos = last;
            return 1'b1;
        end
        hxy = sqr(tx) + sqr(ty);
        rng = int_root(hxy + sqr(tz));
        hxy = int_root(hxy);
        az = (hxy == 0) ? 0 : vector_angle(ty, tx);
        if (az > HALF_TURN) az = HALF_TURN;
        if (az < -HALF_TURN) az = -HALF_TURN;
        pol = (rng == 0) ? QUARTER_TURN : vector_angle(longint'(hxy), tz);
        if (pol > HALF_TURN) pol = HALF_TURN;
        if (pol < 0) pol = 0;
        if (pt_count < MAX_POINTS) begin
            pan_acc += az[31:0];
            tilt_acc += pol[31:0];
            dist_acc += rng[47:0];
            pt_count++;
        end
        if (!last) return 1'b0;
        cnt = (pt_count != 0) ? pt_count : 1;
        s = longint'($signed(pan_acc));
        pavg = (s >= 0) ? s / longint'(cnt) : -((-s + longint'(cnt) - 1) / longint'(cnt));
        pavg = ((pavg + FULL_TURN) % FULL_TURN + FULL_TURN) % FULL_TURN;
        tavg = longint'(tilt_acc) / cnt;
        davg = longint'(dist_acc) / cnt;
        if (davg > 64'hFFFF_FFFF) davg = 64'hFFFF_FFFF;
        res.pan = pavg[11:0];
        res.tilt = (tavg > QUARTER_TURN) ? 10'(tavg - QUARTER_TURN) : 10'd0;
        res.rng = davg[31:0];
        res.eos = 1'b1;
        pt_count = 0;
        pan_acc = '0;
        tilt_acc = '0;
        dist_acc = '0;
        return 1'b1;
    endfunction

    // inputs change on the falling edge
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < REG_MODE) coef_q[idx] = val;
        else if (idx == REG_MODE) mode_q = val[0];
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last,
                              bit typed = 0, pose_t typed_res = '0);
        pose_t res;
        @(negedge aclk);
        if ($urandom_range(99) < sidle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_pose(x, y, z, last, res))
            pose_q.insert(pose_q.size(), typed ? typed_res : res);
    endtask

    // wait out every expected word plus the time the block may still be busy
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
            2: case ($urandom_range(4))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'hFFFF_FFFF;
                   3: return 32'd0;
                   default: return 32'h0001_0000;
               endcase
            default: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        endcase
    endfunction

    function automatic logic [31:0] rand_half(int kind);
        case (kind)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
            default: return 32'h0001_0000;
        endcase
    endfunction

    // receiver side: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= ridle_pct);
        end
    end

    always @(posedge aclk) begin
        pose_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[107:96],
                   m_tdata[117:108], m_tdata[149:118], m_tlast};
            if (pose_q.size() == 0) begin
                report_mismatch("unexpected word", got.rng, 0);
            end else begin
                want = pose_q.pop_front();
                if (got.ox != want.ox) report_mismatch("out_x", got.ox, want.ox);
                if (got.oy != want.oy) report_mismatch("out_y", got.oy, want.oy);
                if (got.oz != want.oz) report_mismatch("out_z", got.oz, want.oz);
                if (got.pan != want.pan) report_mismatch("pan", got.pan, want.pan);
                if (got.tilt != want.tilt) report_mismatch("tilt", got.tilt, want.tilt);
                if (got.rng != want.rng) report_mismatch("distance", got.rng, want.rng);
                if (got.eos != want.eos) report_mismatch("end_of_set", got.eos, want.eos);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            still_cnt <= 0;
        end else begin
            still_cnt <= still_cnt + 1;
            if (still_cnt > STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    dir_row_t dir_rows [] = '{
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1, pose_t'{eos: 1'b1, default: '0}},
        '{32'h0001_0000, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
        '{32'd0, 32'd0, 32'hFFFF_0000, 1'b1, 1'b1, 1'b0, '0},
        '{32'hFFFF_0000, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
        '{32'd0, 32'hFFFF_0000, 32'd0, 1'b1, 1'b1, 1'b0, '0},
        '{32'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b1, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, '0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b0, '0},
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
        '{32'h0001_0000, 32'h0001_0000, 32'd0, 1'b1, 1'b1, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, 1'b0, 1'b1,
          pose_t'{ox: 32'h7FFF_FFFF, oy: 32'h8000_0000, default: '0}},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
          pose_t'{ox: 32'h8000_0000, oy: 32'h7FFF_FFFF, oz: 32'hFFFF_FFFF, eos: 1'b1,
                  default: '0}},
        '{32'd12345, 32'hFFFF_FFF9, 32'h0001_0000, 1'b1, 1'b0, 1'b1,
          pose_t'{ox: 32'd12345, oy: 32'hFFFF_FFF9, oz: 32'h0001_0000, eos: 1'b1,
                  default: '0}}
    };

    initial begin
        int n, len;
        coef_q = '{64'h0001_0000_0000_0000, 64'd0, 64'h0000_0000_0001_0000, 64'd0,
                   64'd0, 64'h0001_0000_0000_0000};
        mode_q = 1'b1;
        pt_count = 0;
        pan_acc = '0;
        tilt_acc = '0;
        dist_acc = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != mode_q) begin
                drain();
                write_reg(REG_MODE, 64'(dir_rows[i].mode));
            end
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last,
                       dir_rows[i].typed, dir_rows[i].res);
        end
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            sidle_pct = (ph < 3) ? 6 : (ph < 6) ? 71 : 0;
            ridle_pct = (ph < 3) ? 71 : (ph < 6) ? 6 : 0;
            for (int r = 0; r < 6; r++) begin
                if (ph == 0) write_reg(3'(r), {rand_half(0), rand_half(0)});
                else if (ph == 1) write_reg(3'(r), {rand_half(1), rand_half(1)});
                else if (ph == 2) write_reg(3'(r), 64'hFFFF_FFFF_FFFF_FFFF);
                else write_reg(3'(r), {rand_half($urandom_range(4)),
                                       rand_half($urandom_range(4))});
            end
            write_reg(REG_MODE, 64'(ph % 2));
            if (ph == 4) hold_req++;
            n = 0;
            while (n < 30) begin
                len = (mode_q == 1'b0) ? 1 : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    // occasional stray end marks split a set early
                    send_point(rand_coord(), rand_coord(), rand_coord(),
                               (k == len - 1) ? ($urandom_range(9) != 0)
                                              : ($urandom_range(19) == 0));
                    n++;
                end
            end
            drain();
        end

        // more points than the set can hold: the tail is left out of the averages
        sidle_pct = 0;
        ridle_pct = 0;
        write_reg(REG_R0_C01, 64'h0001_0000_0000_0000);
        write_reg(REG_R0_C23, 64'd0);
        write_reg(REG_R1_C01, 64'h0000_0000_0001_0000);
        write_reg(REG_R1_C23, 64'd0);
        write_reg(REG_R2_C01, 64'd0);
        write_reg(REG_R2_C23, 64'h0001_0000_0000_0000);
        write_reg(REG_MODE, 64'd1);
        for (int k = 0; k < MAX_POINTS + 6; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), k == MAX_POINTS + 5);
        drain();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
